FILE: rtl/lcr_pkg.sv
// Shared types and constants for the lexeme class recognizer.
package lcr_pkg;

   // Class codes returned with the final character of a lexeme
   typedef enum logic [2:0] {
      CLS_KEYWORD = 3'd0,
      CLS_IDENT   = 3'd1,
      CLS_OPER    = 3'd2,
      CLS_SEP     = 3'd3,
      CLS_BRACKET = 3'd4,
      CLS_NUMBER  = 3'd5,
      CLS_UNKNOWN = 3'd6
   } token_class_type;

   // Progress of the numeric-literal check
   typedef enum logic [1:0] {
      PH_INT  = 2'd0,
      PH_DOT  = 2'd1,
      PH_FRAC = 2'd2,
      PH_REJ  = 2'd3
   } number_phase_type;

   localparam int NUM_KEYWORDS = 8;
   localparam int POS_W        = 3;

   // Keyword text, first character in the lowest byte, zero padded to 8 bytes
   localparam logic [63:0] KW_TEXT [NUM_KEYWORDS] = '{
      64'h0000_0000_0000_6669,   // if
      64'h0000_0000_0074_6E69,   // int
      64'h0000_0000_7261_6863,   // char
      64'h0000_0000_6573_6C65,   // else
      64'h0000_0000_6469_6F76,   // void
      64'h0000_0074_616F_6C66,   // float
      64'h0000_656C_6275_6F64,   // double
      64'h0000_6E72_7574_6572    // return
   };

   localparam logic [POS_W-1:0] KW_LEN [NUM_KEYWORDS] = '{
      3'd2, 3'd3, 3'd4, 3'd4, 3'd4, 3'd5, 3'd6, 3'd6
   };

   localparam logic [POS_W-1:0] POS_MAX = 3'd7;

endpackage

FILE: rtl/lexeme_class_recognizer.sv
// Top level of the lexeme class recognizer: per-character state and class output.
//
//   channel | dir | tdata fields (low bit up)     | tuser / tlast
//   --------+-----+-------------------------------+-----------------------------
//   req_    | in  | ch[7:0]                       | tlast = final character
//   rsp_    | out | token_class[2:0], zeros [7:3] | none
//
// One character is taken every cycle unless a pending result is stalled; the
// per-character state update and the
// class decision are one level of logic between the state registers and the
// result register. A class transaction leaves in the cycle after the final
// character is taken. Reset clears the lexeme state and drops any pending result.
// A stalled result holds; a new character is still taken when the pending result is taken in the same cycle.
module lexeme_class_recognizer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] ch
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata     // [2:0] token_class, [7:3] zero
);

   // character helpers
   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_oper(input logic [7:0] c);
      return c == 8'h2B || c == 8'h2D || c == 8'h2A || c == 8'h2F || c == 8'h21 ||
             c == 8'h26 || c == 8'h25 || c == 8'h3D || c == 8'h3C || c == 8'h3E ||
             c == 8'h7E || c == 8'h7C || c == 8'h5E;
   endfunction

   function automatic logic is_bracket(input logic [7:0] c);
      return c == 8'h28 || c == 8'h29 || c == 8'h7B || c == 8'h7D ||
             c == 8'h5B || c == 8'h5D;
   endfunction

   function automatic logic is_sep(input logic [7:0] c);
      return c == 8'h3A || c == 8'h3B || c == 8'h2C || c == 8'h22;
   endfunction

   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_DOT        = 8'h2E;
   localparam logic [7:0] CH_QUOTE      = 8'h27;

   logic [lcr_pkg::POS_W-1:0]        pos_ff, pos_in;
   logic [lcr_pkg::NUM_KEYWORDS-1:0] cand_ff, cand_in;
   logic                             idok_ff, idok_in;
   logic [7:0]                       first_ff, first_in;
   lcr_pkg::number_phase_type        phase_ff, phase_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   lcr_pkg::token_class_type         rsp_class_ff, rsp_class_in;

   logic                             accept;
   logic                             kw_hit;
   logic [7:0]                       ch;
   logic                             first_pos;
   lcr_pkg::token_class_type         cls;

   assign ch         = req_tdata;
   assign first_pos  = (pos_ff == '0);
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // narrow the keyword candidates by the current character
   always_comb begin
      cand_in = '0;
      kw_hit  = 1'b0;
      for (int k = 0; k < lcr_pkg::NUM_KEYWORDS; k++) begin
         if (cand_ff[k] && pos_ff < lcr_pkg::KW_LEN[k] &&
             ch == lcr_pkg::KW_TEXT[k][{pos_ff, 3'b000} +: 8]) begin
            cand_in[k] = 1'b1;
            if (lcr_pkg::KW_LEN[k] == lcr_pkg::POS_W'(pos_ff + 1'b1)) begin
               kw_hit = 1'b1;
            end
         end
      end
   end

   // advance identifier, number and first-character tracking
   always_comb begin
      if (first_pos) begin
         idok_in  = is_letter(ch) || ch == CH_UNDERSCORE;
         phase_in = is_digit(ch) ? lcr_pkg::PH_INT :
                    (ch == CH_DOT ? lcr_pkg::PH_DOT : lcr_pkg::PH_REJ);
         first_in = ch;
      end else begin
         idok_in  = idok_ff && (is_letter(ch) || is_digit(ch) || ch == CH_UNDERSCORE);
         first_in = first_ff;
         unique case (phase_ff)
            lcr_pkg::PH_INT: begin
               phase_in = is_digit(ch) ? lcr_pkg::PH_INT :
                          (ch == CH_DOT ? lcr_pkg::PH_DOT : lcr_pkg::PH_REJ);
            end
            lcr_pkg::PH_DOT, lcr_pkg::PH_FRAC: begin
               phase_in = is_digit(ch) ? lcr_pkg::PH_FRAC : lcr_pkg::PH_REJ;
            end
            default: begin
               phase_in = lcr_pkg::PH_REJ;
            end
         endcase
      end
      pos_in = (pos_ff == lcr_pkg::POS_MAX) ? lcr_pkg::POS_MAX
                                            : lcr_pkg::POS_W'(pos_ff + 1'b1);
   end

   // pick the class in priority order
   always_comb begin
      priority if (kw_hit) begin
         cls = lcr_pkg::CLS_KEYWORD;
      end else if (idok_in) begin
         cls = lcr_pkg::CLS_IDENT;
      end else if (is_oper(first_in)) begin
         cls = lcr_pkg::CLS_OPER;
      end else if (is_sep(first_in) || (first_pos && first_in == CH_QUOTE)) begin
         cls = lcr_pkg::CLS_SEP;
      end else if (is_bracket(first_in)) begin
         cls = lcr_pkg::CLS_BRACKET;
      end else if (phase_in == lcr_pkg::PH_INT || phase_in == lcr_pkg::PH_FRAC) begin
         cls = lcr_pkg::CLS_NUMBER;
      end else begin
         cls = lcr_pkg::CLS_UNKNOWN;
      end
   end

   // load the result register on the final character, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_class_in = rsp_class_ff;
      if (accept && req_tlast) begin
         rsp_valid_in = 1'b1;
         rsp_class_in = cls;
      end
   end

   // hold lexeme state; return to the start state after the final character
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         cand_ff      <= '1;
         idok_ff      <= 1'b1;
         first_ff     <= '0;
         phase_ff     <= lcr_pkg::PH_INT;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            if (req_tlast) begin
               pos_ff   <= '0;
               cand_ff  <= '1;
               idok_ff  <= 1'b1;
               first_ff <= '0;
               phase_ff <= lcr_pkg::PH_INT;
            end else begin
               pos_ff   <= pos_in;
               cand_ff  <= cand_in;
               idok_ff  <= idok_in;
               first_ff <= first_in;
               phase_ff <= phase_in;
            end
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_class_ff <= rsp_class_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b00000, rsp_class_ff};

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the lexeme class recognizer: streams random lexemes and checks each class.
`timescale 1ns / 100ps

module tb_top;

   localparam int STALL_LIMIT  = 2000;
   localparam int TARGET_CHARS = 1800;
   localparam int CALM_CHARS   = 1500;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;    // [7:0] ch
   logic       req_tlast;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;    // [2:0] token_class, [7:3] zero

   // Predicts the class of each lexeme and holds the classes still to come
   class lexeme_scoreboard;
      logic [2:0]                char_pos;
      logic [7:0]                kw_live;
      bit                        ident_ok;
      logic [7:0]                lead_char;
      lcr_pkg::number_phase_type num_phase;
      lcr_pkg::token_class_type  class_queue [$];
      int                        n_errors;
      int                        n_chars;
      int                        class_seen [7];

      function new();
         n_errors = 0;
         n_chars  = 0;
         foreach (class_seen[i]) class_seen[i] = 0;
         clear_lexeme();
      endfunction

      static function string keyword_text(int k);
         case (k)
            0: return "if";
            1: return "int";
            2: return "char";
            3: return "else";
            4: return "void";
            5: return "float";
            6: return "double";
            default: return "return";
         endcase
      endfunction

      static function bit is_letter(logic [7:0] c);
         return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
      endfunction

      static function bit is_digit(logic [7:0] c);
         return c >= "0" && c <= "9";
      endfunction

      static function bit is_oper(logic [7:0] c);
         return c == "+" || c == "-" || c == "*" || c == "/" || c == "!" ||
                c == "&" || c == "%" || c == "=" || c == "<" || c == ">" ||
                c == "~" || c == "|" || c == "^";
      endfunction

      static function bit is_bracket(logic [7:0] c);
         return c == "(" || c == ")" || c == "{" || c == "}" || c == "[" || c == "]";
      endfunction

      function void clear_lexeme();
         char_pos  = '0;
         kw_live   = 8'hFF;
         ident_ok  = 1'b1;
         lead_char = 8'h00;
         num_phase = lcr_pkg::PH_INT;
      endfunction

      // Advance the lexeme state by one accepted character
      function void note_char(logic [7:0] ch, bit last);
         logic [7:0]                cand;
         bit                        hit;
         bit                        ok;
         logic [7:0]                lead;
         lcr_pkg::number_phase_type ph;
         lcr_pkg::token_class_type  cls;
         string                     w;
         cand = '0;
         hit  = 1'b0;
         n_chars++;
         for (int k = 0; k < lcr_pkg::NUM_KEYWORDS; k++) begin
            w = keyword_text(k);
            if (kw_live[k] && char_pos < w.len() && ch == w[char_pos]) begin
               cand[k] = 1'b1;
               if (w.len() == char_pos + 1) hit = 1'b1;
            end
         end
         if (char_pos == 0) begin
            ok   = is_letter(ch) || ch == "_";
            ph   = is_digit(ch) ? lcr_pkg::PH_INT :
                   (ch == "." ? lcr_pkg::PH_DOT : lcr_pkg::PH_REJ);
            lead = ch;
         end else begin
            ok = ident_ok && (is_letter(ch) || is_digit(ch) || ch == "_");
            case (num_phase)
               lcr_pkg::PH_INT:  ph = is_digit(ch) ? lcr_pkg::PH_INT :
                                      (ch == "." ? lcr_pkg::PH_DOT : lcr_pkg::PH_REJ);
               lcr_pkg::PH_DOT,
               lcr_pkg::PH_FRAC: ph = is_digit(ch) ? lcr_pkg::PH_FRAC : lcr_pkg::PH_REJ;
               default: ph = lcr_pkg::PH_REJ;
            endcase
            lead = lead_char;
         end
         if (!last) begin
            kw_live   = cand;
            ident_ok  = ok;
            num_phase = ph;
            lead_char = lead;
            if (char_pos != lcr_pkg::POS_MAX) char_pos = char_pos + 1'b1;
         end else begin
            // Resolve the class in priority order
            if (hit) cls = lcr_pkg::CLS_KEYWORD;
            else if (ok) cls = lcr_pkg::CLS_IDENT;
            else if (is_oper(lead)) cls = lcr_pkg::CLS_OPER;
            else if (lead == ":" || lead == ";" || lead == "," || lead == "\"" ||
                     (char_pos == 0 && lead == "'")) cls = lcr_pkg::CLS_SEP;
            else if (is_bracket(lead)) cls = lcr_pkg::CLS_BRACKET;
            else if (ph == lcr_pkg::PH_INT || ph == lcr_pkg::PH_FRAC) cls = lcr_pkg::CLS_NUMBER;
            else cls = lcr_pkg::CLS_UNKNOWN;
            class_queue.push_back(cls);
            clear_lexeme();
         end
      endfunction

      // Compare one class transaction with the oldest prediction
      function void check_class(logic [7:0] data);
         lcr_pkg::token_class_type want;
         if (class_queue.size() == 0) begin
            $error("unexpected class transaction: token_class %0d", data[2:0]);
            n_errors++;
         end else begin
            want = class_queue.pop_front();
            class_seen[want]++;
            if (data[2:0] !== want) begin
               $error("token_class mismatch: expected %0d, actual %0d", want, data[2:0]);
               n_errors++;
            end
         end
      endfunction
   endclass

   lexeme_scoreboard sb;
   logic [7:0]       lex_buf [$];
   bit               idle_on;
   int               n_lexemes;

   lexeme_class_recognizer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Free-running clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Stall the class channel in random bursts
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // Observe both channels at each edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_char(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) sb.check_class(rsp_tdata);
      end
   end

   // Abort when nothing moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("Some tests failed");
      $finish;
   end

   // Drive one character transaction, with an optional gap ahead of it
   task automatic send_char(logic [7:0] ch, bit last);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_lexeme();
      foreach (lex_buf[i]) send_char(lex_buf[i], i == lex_buf.size() - 1);
      n_lexemes++;
      lex_buf.delete();
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) lex_buf.push_back(s[i]);
      send_lexeme();
   endtask

   function automatic logic [7:0] rand_letter();
      return $urandom_range(0, 1) ? 8'($urandom_range("a", "z")) : 8'($urandom_range("A", "Z"));
   endfunction

   function automatic logic [7:0] rand_digit();
      return 8'($urandom_range("0", "9"));
   endfunction

   function automatic logic [7:0] rand_word_char();
      case ($urandom_range(0, 3))
         0, 1:    return rand_letter();
         2:       return rand_digit();
         default: return "_";
      endcase
   endfunction

   task automatic push_digits(int n);
      repeat (n) lex_buf.push_back(rand_digit());
   endtask

   // Build one random lexeme, mostly well formed, into lex_buf
   task automatic make_random_lexeme();
      string w;
      int    n;
      w = lexeme_scoreboard::keyword_text($urandom_range(0, lcr_pkg::NUM_KEYWORDS - 1));
      case ($urandom_range(0, 11))
         0, 1: begin
            for (int i = 0; i < w.len(); i++) lex_buf.push_back(w[i]);
         end
         2: begin
            case ($urandom_range(0, 2))
               0: begin
                  n = $urandom_range(1, w.len() - 1);
                  for (int i = 0; i < n; i++) lex_buf.push_back(w[i]);
               end
               1: begin
                  for (int i = 0; i < w.len(); i++) lex_buf.push_back(w[i]);
                  repeat ($urandom_range(1, 2)) lex_buf.push_back(rand_word_char());
               end
               default: begin
                  for (int i = 0; i < w.len(); i++) lex_buf.push_back(w[i]);
                  lex_buf[$urandom_range(0, w.len() - 1)] = rand_word_char();
               end
            endcase
         end
         3: begin
            lex_buf.push_back($urandom_range(0, 4) ? rand_letter() : 8'("_"));
            repeat ($urandom_range(0, 9)) lex_buf.push_back(rand_word_char());
         end
         4: begin
            w = "+-*/!&%=<>~|^";
            lex_buf.push_back(w[$urandom_range(0, w.len() - 1)]);
            repeat ($urandom_range(0, 3)) lex_buf.push_back(8'($urandom_range(32, 126)));
         end
         5: begin
            w = ":;,\"'";
            lex_buf.push_back(w[$urandom_range(0, w.len() - 1)]);
            if ($urandom_range(0, 1))
               repeat ($urandom_range(1, 3)) lex_buf.push_back(8'($urandom_range(32, 126)));
         end
         6: begin
            w = "(){}[]";
            lex_buf.push_back(w[$urandom_range(0, w.len() - 1)]);
            repeat ($urandom_range(0, 2)) lex_buf.push_back(8'($urandom_range(32, 126)));
         end
         7, 8: begin
            case ($urandom_range(0, 6))
               0: push_digits($urandom_range(1, 6));
               1: begin
                  push_digits($urandom_range(1, 4));
                  lex_buf.push_back(".");
                  push_digits($urandom_range(1, 4));
               end
               2: begin
                  lex_buf.push_back(".");
                  push_digits($urandom_range(1, 5));
               end
               3: begin
                  push_digits($urandom_range(1, 3));
                  lex_buf.push_back(".");
               end
               4: lex_buf.push_back(".");
               5: begin
                  push_digits($urandom_range(1, 2));
                  lex_buf.push_back(".");
                  push_digits($urandom_range(1, 2));
                  lex_buf.push_back(".");
                  push_digits($urandom_range(0, 2));
               end
               default: begin
                  push_digits($urandom_range(1, 3));
                  lex_buf.push_back(rand_letter());
               end
            endcase
         end
         9: repeat ($urandom_range(1, 10)) lex_buf.push_back(8'($urandom_range(0, 255)));
         10: repeat ($urandom_range(8, 14)) lex_buf.push_back(rand_word_char());
         default: repeat ($urandom_range(1, 6)) lex_buf.push_back(8'($urandom_range(32, 126)));
      endcase
   endtask

   // Reset, directed lexemes, random lexemes, then drain and report
   initial begin
      sb         = new();
      idle_on    = 1'b1;
      n_lexemes  = 0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tlast  = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Cover each class and the edge cases once
      send_text("if");
      send_text("_a");
      send_text("~");
      send_text("^");
      send_text(";");
      send_text("'");
      send_text("]");
      send_text("1.5");
      send_text(".5");
      send_text("1.");
      lex_buf = '{8'h00};
      send_lexeme();
      lex_buf = '{8'hFF};
      send_lexeme();
      send_text("abcdefgh");

      // Random lexemes; drop idling for the last stretch
      while (sb.n_chars < TARGET_CHARS) begin
         if (sb.n_chars >= CALM_CHARS) idle_on = 1'b0;
         make_random_lexeme();
         send_lexeme();
      end
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;

      while (sb.class_queue.size() > 0) @(posedge clock);
      repeat (5) @(posedge clock);

      $display("Classified %0d lexemes from %0d characters", n_lexemes, sb.n_chars);
      $display("kw %0d, ident %0d, oper %0d, sep %0d, bracket %0d, number %0d, unknown %0d",
               sb.class_seen[lcr_pkg::CLS_KEYWORD], sb.class_seen[lcr_pkg::CLS_IDENT],
               sb.class_seen[lcr_pkg::CLS_OPER], sb.class_seen[lcr_pkg::CLS_SEP],
               sb.class_seen[lcr_pkg::CLS_BRACKET], sb.class_seen[lcr_pkg::CLS_NUMBER],
               sb.class_seen[lcr_pkg::CLS_UNKNOWN]);
      if (sb.n_errors == 0 && sb.class_queue.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
